// ===== rtl/pcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcrc_pkg
// Shared constants and interface types for the per-core rate cache with
// cycle-to-microsecond conversion.
// ----------------------------------------------------------------------------
package pcrc_pkg;

  // Field widths
  localparam int CORE_W   = 32;
  localparam int CYCLE_W  = 64;
  localparam int RATE_W   = 16;

  // Rate table geometry (valid range 1..64)
  localparam int SLOTS    = 8;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Divider: one quotient bit per cycle
  localparam int DIV_STEPS = CYCLE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Fallback rate after reset, cycles per microsecond
  localparam logic [RATE_W-1:0] RESET_FALLBACK = RATE_W'(2000);

  // Lookup request to the rate table
  typedef struct packed {
    logic              lookup;
    logic [CORE_W-1:0] core;
    logic [RATE_W-1:0] measured;
    logic [RATE_W-1:0] fallback;
  } tbl_req_t;

  // Lookup answer from the rate table
  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              hit;
  } tbl_rsp_t;

  // Divide request
  typedef struct packed {
    logic               start;
    logic [CYCLE_W-1:0] dividend;
    logic [RATE_W-1:0]  divisor;
  } div_req_t;

  // Divide status and result
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [CYCLE_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/pcrc_table.sv =====
// ----------------------------------------------------------------------------
// pcrc_table
// Last-used register plus a fully associative rate table keyed by core id,
// with round-robin replacement on a miss.
// ----------------------------------------------------------------------------
module pcrc_table (
  input  logic               clk,
  input  logic               rst_n,
  input  pcrc_pkg::tbl_req_t req,
  output pcrc_pkg::tbl_rsp_t rsp
);

  // Last-used register
  logic                          last_valid_r;
  logic [pcrc_pkg::CORE_W-1:0]   last_core_r;
  logic [pcrc_pkg::RATE_W-1:0]   last_rate_r;

  // Table storage
  logic [pcrc_pkg::CORE_W-1:0]   entry_core_r  [pcrc_pkg::SLOTS];
  logic [pcrc_pkg::RATE_W-1:0]   entry_rate_r  [pcrc_pkg::SLOTS];
  logic [pcrc_pkg::SLOTS-1:0]    entry_valid_r;
  logic [pcrc_pkg::SLOT_W-1:0]   ptr_r;
  logic [pcrc_pkg::SLOT_W-1:0]   ptr_nxt;

  logic                          last_hit;
  logic                          tbl_hit;
  logic [pcrc_pkg::SLOT_W-1:0]   hit_idx;
  logic [pcrc_pkg::RATE_W-1:0]   miss_rate;

  // Last register match
  assign last_hit = last_valid_r && (last_core_r == req.core);

  // Table search, lowest matching slot wins
  always_comb begin
    tbl_hit = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < pcrc_pkg::SLOTS; i++) begin
      if (!tbl_hit && entry_valid_r[i] && (entry_core_r[i] == req.core)) begin
        tbl_hit = 1'b1;
        hit_idx = pcrc_pkg::SLOT_W'(i);
      end
    end
  end

  // Rate inserted on a miss; zero measurement falls back, zero fallback is 1
  always_comb begin
    if (req.measured != '0) begin
      miss_rate = req.measured;
    end else if (req.fallback != '0) begin
      miss_rate = req.fallback;
    end else begin
      miss_rate = pcrc_pkg::RATE_W'(1);
    end
  end

  // Answer
  always_comb begin
    if (last_hit) begin
      rsp.rate = last_rate_r;
      rsp.hit  = 1'b1;
    end else if (tbl_hit) begin
      rsp.rate = entry_rate_r[hit_idx];
      rsp.hit  = 1'b1;
    end else begin
      rsp.rate = miss_rate;
      rsp.hit  = 1'b0;
    end
  end

  // Round-robin pointer advance
  assign ptr_nxt = (ptr_r == pcrc_pkg::SLOT_W'(pcrc_pkg::SLOTS - 1)) ?
                   '0 : ptr_r + pcrc_pkg::SLOT_W'(1);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_valid_r  <= 1'b0;
      entry_valid_r <= '0;
      ptr_r         <= '0;
    end else if (req.lookup && !last_hit) begin
      last_valid_r <= 1'b1;
      if (!tbl_hit) begin
        entry_valid_r[ptr_r] <= 1'b1;
        ptr_r                <= ptr_nxt;
      end
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (req.lookup && !last_hit) begin
      last_core_r <= req.core;
      last_rate_r <= rsp.rate;
      if (!tbl_hit) begin
        entry_core_r[ptr_r] <= req.core;
        entry_rate_r[ptr_r] <= miss_rate;
      end
    end
  end

  // A miss fills the slot under the pointer
  a_miss_fills: assert property (@(posedge clk) disable iff (!rst_n)
    req.lookup && !rsp.hit |=> entry_valid_r[$past(ptr_r)])
    else $error("missed slot not marked valid");

  // Any lookup leaves the last register loaded
  a_last_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    req.lookup |=> last_valid_r)
    else $error("last register not valid after lookup");

endmodule

// ===== rtl/pcrc_divider.sv =====
// ----------------------------------------------------------------------------
// pcrc_divider
// Restoring divider, 64-bit dividend by 16-bit divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module pcrc_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  pcrc_pkg::div_req_t req,
  output pcrc_pkg::div_rsp_t rsp
);

  logic                           busy_r;
  logic                           done_r;
  logic [pcrc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [pcrc_pkg::RATE_W-1:0]    divisor_r;
  logic [pcrc_pkg::RATE_W-1:0]    rem_r;
  logic [pcrc_pkg::CYCLE_W-1:0]   quo_r;

  logic [pcrc_pkg::RATE_W:0]      trial;
  logic [pcrc_pkg::RATE_W:0]      diff;
  logic                           ge;
  logic [pcrc_pkg::RATE_W-1:0]    rem_nxt;

  // Shift in next dividend bit and try to subtract
  assign trial   = {rem_r, quo_r[pcrc_pkg::CYCLE_W-1]};
  assign diff    = trial - {1'b0, divisor_r};
  assign ge      = trial >= {1'b0, divisor_r};
  assign rem_nxt = ge ? diff[pcrc_pkg::RATE_W-1:0] : trial[pcrc_pkg::RATE_W-1:0];

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + pcrc_pkg::DIV_CNT_W'(1);
        if (cnt_r == pcrc_pkg::DIV_CNT_W'(pcrc_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor_r <= req.divisor;
      rem_r     <= '0;
      quo_r     <= req.dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[pcrc_pkg::CYCLE_W-2:0], ge};
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  // Final remainder is below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < divisor_r)
    else $error("remainder not below divisor at completion");

endmodule

// ===== rtl/per_core_rate_cache_time_convert.sv =====
// ----------------------------------------------------------------------------
// per_core_rate_cache_time_convert
// Converts a raw cycle count to microseconds using a per-core rate cache.
// ----------------------------------------------------------------------------
// One transaction at a time: an item is taken when the block is idle, the
// core is looked up (last-used register, then an 8-slot table, inserting
// the supplied rate on a miss), then a shared restoring divider produces
// the quotient one bit per cycle. An item passes from acceptance through
// S_LOOK, S_DIV and S_DONE into the output register; the 64-step divider
// runs in S_DIV. The next item can be taken in the cycle after the result
// is loaded, not before. The result sits in an output register, so a new
// item is taken while it waits. The fallback rate register resets to 2000
// and is written through cfg_*, which is always ready; write it only while
// the block is idle.
module per_core_rate_cache_time_convert (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pcrc_pkg::CORE_W-1:0]   in_core_id,
  input  logic [pcrc_pkg::CYCLE_W-1:0]  in_cycle_count,
  input  logic [pcrc_pkg::RATE_W-1:0]   in_measured_rate,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pcrc_pkg::CYCLE_W-1:0]  out_microseconds,
  output logic [pcrc_pkg::RATE_W-1:0]   out_rate_used,
  output logic                          out_hit,
  // Configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pcrc_pkg::RATE_W-1:0]   cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_DIV,
    S_DONE
  } state_t;

  state_t                        state_r;
  logic [pcrc_pkg::RATE_W-1:0]   fallback_r;
  logic [pcrc_pkg::CORE_W-1:0]   core_r;
  logic [pcrc_pkg::CYCLE_W-1:0]  cycles_r;
  logic [pcrc_pkg::RATE_W-1:0]   measured_r;
  logic [pcrc_pkg::RATE_W-1:0]   rate_r;
  logic                          hit_r;
  logic                          out_valid_r;
  logic [pcrc_pkg::CYCLE_W-1:0]  out_us_r;
  logic [pcrc_pkg::RATE_W-1:0]   out_rate_r;
  logic                          out_hit_r;

  pcrc_pkg::tbl_req_t            tbl_req;
  pcrc_pkg::tbl_rsp_t            tbl_rsp;
  pcrc_pkg::div_req_t            div_req;
  pcrc_pkg::div_rsp_t            div_rsp;
  logic [pcrc_pkg::RATE_W-1:0]   div_rate;
  logic                          in_acc;
  logic                          out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // Rate table
  assign tbl_req.lookup   = (state_r == S_LOOK);
  assign tbl_req.core     = core_r;
  assign tbl_req.measured = measured_r;
  assign tbl_req.fallback = fallback_r;

  pcrc_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rsp   (tbl_rsp)
  );

  // Divider; a zero rate is guarded to 1
  assign div_rate         = (tbl_rsp.rate == '0) ? pcrc_pkg::RATE_W'(1) : tbl_rsp.rate;
  assign div_req.start    = (state_r == S_LOOK);
  assign div_req.dividend = cycles_r;
  assign div_req.divisor  = div_rate;

  pcrc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Fallback rate register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fallback_r <= pcrc_pkg::RESET_FALLBACK;
    end else if (cfg_valid && cfg_ready) begin
      fallback_r <= cfg_data;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // load a new result, or drop the one just taken
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      core_r     <= in_core_id;
      cycles_r   <= in_cycle_count;
      measured_r <= in_measured_rate;
    end
    if (state_r == S_LOOK) begin
      rate_r <= div_rate;
      hit_r  <= tbl_rsp.hit;
    end
    if (state_r == S_DONE && out_free) begin
      out_us_r   <= div_rsp.quotient;
      out_rate_r <= rate_r;
      out_hit_r  <= hit_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_microseconds = out_us_r;
  assign out_rate_used    = out_rate_r;
  assign out_hit          = out_hit_r;

  // Divider completes only while the sequencer waits on it
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide phase");

  // Divider never sees a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> div_req.divisor != '0)
    else $error("zero divisor issued");

  // Divider is running throughout the divide phase until done
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && !div_rsp.done |-> div_rsp.busy)
    else $error("divide phase with idle divider");

endmodule
